[rtl/gnb_pkg.sv]
// gaussian naive bayes engine: shared types and constants
// no dependencies
`default_nettype none
package gnb_pkg;
    localparam int MaxClasses  = 16;
    localparam int MaxFeatures = 64;
    localparam int ClsW  = $clog2(MaxClasses);
    localparam int PosW  = $clog2(MaxFeatures);
    localparam int AddrW = ClsW + PosW;
    localparam int Depth = MaxClasses * MaxFeatures;

    localparam logic [31:0] VarReset = 32'd655;
    localparam logic [47:0] Ln2Q     = 48'd45426;
    localparam logic [47:0] Ln2PiQ   = 48'd120447;
    localparam logic signed [47:0] ScoreMax = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [47:0] ScoreMin = 48'sh8000_0000_0000;

    localparam logic CmdTrain    = 1'b0;
    localparam logic CmdClassify = 1'b1;
    localparam logic RegClasses  = 1'b0;
    localparam logic RegFeatures = 1'b1;

    typedef struct packed {
        logic        command;
        logic [3:0]  class_id;
        logic [31:0] feature_value;
        logic        last_feature;
    } t_in;

    typedef struct packed {
        logic [3:0]  best_class;
        logic        class_found;
        logic [47:0] best_log_likelihood;
        logic [31:0] class_sample_count;
    } t_out;

    typedef struct packed {
        logic        index;
        logic [6:0]  data;
    } t_cfg;

    // request to the shared divider
    typedef struct packed {
        logic        start;
        logic [63:0] num;
        logic [32:0] den;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [63:0] quo;
    } t_div_rsp;
endpackage
`default_nettype wire

[rtl/gnb_if.sv]
// valid/ready channel interfaces for the engine
// depends on gnb_pkg
`default_nettype none
interface gnb_in_if;
    logic         valid;
    logic         ready;
    gnb_pkg::t_in data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface gnb_out_if;
    logic          valid;
    logic          ready;
    gnb_pkg::t_out data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface gnb_cfg_if;
    logic          valid;
    logic          ready;
    gnb_pkg::t_cfg data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

[rtl/gnb_div.sv]
// shared restoring divider, one quotient bit per cycle, 64 by 33 bits
// depends on gnb_pkg
`default_nettype none
module gnb_div (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  gnb_pkg::t_div_req      i_req,
    output gnb_pkg::t_div_rsp      o_rsp
);
    import gnb_pkg::*;

    logic [63:0] r_quo;
    logic [32:0] r_den;
    logic [33:0] r_rem;
    logic [6:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [33:0] w_sh;
    logic [34:0] w_sub;

    assign w_sh  = {r_rem[32:0], r_quo[63]};
    assign w_sub = {1'b0, w_sh} - {2'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 7'd0;
                r_quo  <= i_req.num;
                r_den  <= i_req.den;
                r_rem  <= '0;
            end else if (r_busy) begin
                if (!w_sub[34]) begin
                    r_rem <= w_sub[33:0];
                end else begin
                    r_rem <= w_sh;
                end
                r_quo <= {r_quo[62:0], ~w_sub[34]};
                r_cnt <= r_cnt + 7'd1;
                if (r_cnt == 7'd63) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;
endmodule
`default_nettype wire

[rtl/gaussian_naive_bayes_engine_core.sv]
// gaussian naive bayes engine, one feature beat per transaction
// steps: a train beat runs one divide (count up to 2) or two (mean, then variance);
// a classify beat runs a divide and log per class in use whose mean is above zero and
// skips the others; a last classify beat then sweeps the classes before the result beat
// flow: one beat at a time; the next beat is taken once the unit is back in idle
// reset: config to 16 classes, 64 features; a clearing pass then writes reset values
// into the 1024-entry stores with ready held low
// depends on gnb_pkg, gnb_if, gnb_div
`default_nettype none
module gaussian_naive_bayes_engine_core (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    gnb_in_if.sink     i_in,
    gnb_out_if.source  o_out,
    gnb_cfg_if.sink    i_cfg
);
    import gnb_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_RD, S_RDW, S_TMEAN, S_TMW, S_TVAR, S_TVMUL, S_TVW, S_TWB,
        S_CRD, S_CRDW, S_CSQ, S_CDIV, S_CLOG, S_CLN, S_CACC,
        S_ARG, S_EMIT, S_WAIT, S_CLR
    } t_state;

    t_state       r_state;
    logic [4:0]   r_nc;
    logic [6:0]   r_nf;
    logic [6:0]   r_pos;
    t_in          r_in;

    // memories, filled with reset values by the clearing pass
    logic [31:0]  mem_mean [Depth];
    logic [31:0]  mem_var  [Depth];
    logic [31:0]  r_mrd, r_vrd;
    logic [AddrW-1:0] r_addr;
    logic         r_we;
    logic [31:0]  r_wmean, r_wvar;

    logic [31:0]  r_cnt [MaxClasses];
    logic signed [47:0] r_score [MaxClasses];

    // working registers
    logic signed [33:0] r_delta;
    logic signed [33:0] r_nmean;
    logic [63:0]  r_prod;
    logic [32:0]  r_n;
    logic [ClsW:0] r_c;
    logic [63:0]  r_q;
    logic [32:0]  r_m;
    logic [4:0]   r_b;
    logic [4:0]   r_k;
    logic [15:0]  r_frac;
    logic [31:0]  r_v;
    logic signed [47:0] r_best;
    logic [3:0]   r_bc;
    logic         r_found;

    t_div_req     r_req;
    t_div_rsp     w_rsp;

    gnb_div u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(r_req), .o_rsp(w_rsp));

    logic [4:0]   w_nc;
    logic [6:0]   w_nf;
    logic [31:0]  w_mean, w_var;
    logic signed [33:0] w_x;
    logic [65:0]  w_msq;
    logic [33:0]  w_ad;
    logic [32:0]  w_admag, w_dmag, w_rmag;
    logic signed [33:0] w_r;
    logic [47:0]  w_l, w_lnv;
    logic signed [48:0] w_h;
    logic signed [49:0] w_sum;
    logic [4:0]   w_lz;

    assign w_nc = (r_nc == 5'd0) ? 5'd1 : (r_nc > 5'd16 ? 5'd16 : r_nc);
    assign w_nf = (r_nf == 7'd0) ? 7'd1 : (r_nf > 7'd64 ? 7'd64 : r_nf);
    assign w_mean = r_mrd;
    assign w_var  = r_vrd;
    assign w_x = 34'(signed'(r_in.feature_value));
    assign w_ad = (w_x - 34'(signed'(w_mean)));
    assign w_msq = r_m * r_m;

    // magnitudes, all below 2^33
    assign w_admag = w_ad[33] ? 33'(-w_ad) : w_ad[32:0];
    assign w_r     = w_x - r_nmean;
    assign w_dmag  = r_delta[33] ? 33'(-r_delta) : 33'(r_delta);
    assign w_rmag  = w_r[33] ? 33'(-w_r) : 33'(w_r);

    // highest set bit of variance
    always_comb begin
        w_lz = 5'd0;
        for (int i = 0; i < 32; i++) begin
            if (r_v[i]) w_lz = 5'(i);
        end
    end

    assign w_l   = {27'd0, r_k, r_frac};
    assign w_lnv = 48'((w_l * Ln2Q) >> 16) - (Ln2Q << 4);
    assign w_h   = (49'(signed'(Ln2PiQ)) + 49'(signed'(w_lnv)));

    always_comb begin
        logic signed [48:0] hh;
        hh = w_h[48] ? -((-w_h) >>> 1) : (w_h >>> 1);
        w_sum = 50'(r_score[r_c[ClsW-1:0]]) - 50'(r_q[47:0]) - 50'(hh);
    end

    // config has priority, so a data beat waits while a config beat is offered
    assign i_in.ready  = (r_state == S_IDLE) && !i_cfg.valid;
    assign i_cfg.ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (r_we) begin
            mem_mean[r_addr] <= r_wmean;
            mem_var[r_addr]  <= r_wvar;
        end
        r_mrd <= mem_mean[r_addr];
        r_vrd <= mem_var[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_nc <= 5'd16;
            r_nf <= 7'd64;
            r_pos <= '0;
            r_addr <= '0;
            r_we <= 1'b0;
            o_out.valid <= 1'b0;
            r_req.start <= 1'b0;
            for (int i = 0; i < MaxClasses; i++) begin
                r_cnt[i] <= '0;
                r_score[i] <= '0;
            end
        end else begin
            r_we <= 1'b0;
            r_req.start <= 1'b0;
            unique case (r_state)
                // clearing pass, one entry a cycle
                S_CLR: begin
                    r_wmean <= '0;
                    r_wvar  <= VarReset;
                    if (!r_we) begin
                        r_we <= 1'b1;
                    end else if (r_addr == '1) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_we <= 1'b1;
                        r_addr <= r_addr + 1'b1;
                    end
                end
                S_IDLE: begin
                    if (i_cfg.valid) begin
                        if (i_cfg.data.index == RegClasses) r_nc <= i_cfg.data.data[4:0];
                        else r_nf <= i_cfg.data.data;
                    end else if (i_in.valid) begin
                        r_in <= i_in.data;
                        if (r_pos == 7'd0) begin
                            for (int i = 0; i < MaxClasses; i++) r_score[i] <= '0;
                        end
                        if (i_in.data.command == CmdTrain) begin
                            if (r_pos == 7'd0 && r_cnt[i_in.data.class_id] != '1)
                                r_cnt[i_in.data.class_id] <= r_cnt[i_in.data.class_id] + 32'd1;
                            r_addr <= {i_in.data.class_id, r_pos[PosW-1:0]};
                            r_state <= (r_pos < w_nf) ? S_RD : S_ARG;
                        end else begin
                            r_c <= '0;
                            r_state <= (r_pos < w_nf) ? S_CRD : S_ARG;
                        end
                    end
                end
                // train path
                S_RD: begin
                    r_state <= S_RDW;
                    r_n <= {1'b0, r_cnt[r_in.class_id]};
                end
                S_RDW: begin
                    if (r_n == '0) begin
                        r_state <= S_ARG;
                    end else begin
                        r_delta <= w_ad;
                        r_req.start <= 1'b1;
                        r_req.num <= 64'(w_admag);
                        r_req.den <= r_n;
                        r_state <= S_TMEAN;
                    end
                end
                S_TMEAN: begin
                    if (w_rsp.done) begin
                        r_nmean <= 34'(signed'(w_mean)) +
                            (r_delta[33] ? -34'(w_rsp.quo) : 34'(w_rsp.quo));
                        r_state <= S_TMW;
                    end
                end
                S_TMW: begin
                    r_wmean <= r_nmean[31:0];
                    r_wvar  <= w_var;
                    if (r_n > 33'd2) begin
                        r_prod <= 64'(w_dmag) * 64'(w_rmag);
                        r_state <= S_TVAR;
                    end else begin
                        r_state <= S_TWB;
                    end
                end
                S_TVAR: begin
                    r_q <= 64'(w_var) * 64'(r_n - 33'd2);
                    r_state <= S_TVMUL;
                end
                S_TVMUL: begin
                    r_req.start <= 1'b1;
                    r_req.num <= r_q + (r_prod >> 16);
                    r_req.den <= r_n - 33'd1;
                    r_state <= ((r_q + (r_prod >> 16)) < r_q) ? S_TWB : S_TVW;
                    if ((r_q + (r_prod >> 16)) < r_q) r_wvar <= '1;
                end
                S_TVW: begin
                    if (w_rsp.done) begin
                        r_wvar <= (w_rsp.quo[63:32] != '0) ? '1 : w_rsp.quo[31:0];
                        r_state <= S_TWB;
                    end
                end
                S_TWB: begin
                    r_we <= 1'b1;
                    r_state <= S_ARG;
                end
                // classify path, one class at a time
                S_CRD: begin
                    r_addr <= {r_c[ClsW-1:0], r_pos[PosW-1:0]};
                    r_state <= S_CRDW;
                end
                S_CRDW: r_state <= S_CSQ;
                S_CSQ: begin
                    if ($signed(w_mean) > 0) begin
                        r_v <= (w_var == '0) ? 32'd1 : w_var;
                        r_m <= w_admag;
                        r_state <= S_CDIV;
                    end else begin
                        r_state <= S_CACC;
                        r_q <= '1;
                    end
                end
                S_CDIV: begin
                    r_req.start <= 1'b1;
                    r_req.num <= w_msq[63:0];
                    r_req.den <= {r_v, 1'b0};
                    r_state <= S_CLOG;
                    r_k <= w_lz;
                    r_m <= {1'b0, r_v} << (5'd31 - w_lz);
                    r_b <= 5'd16;
                    r_frac <= '0;
                end
                S_CLOG: begin
                    // log squarings run alongside the divide
                    if (r_b != 5'd0) begin
                        if (w_msq[65:63] != 3'd0) begin
                            r_m <= w_msq[64:32];
                            r_frac[4'(r_b - 5'd1)] <= 1'b1;
                        end else begin
                            r_m <= w_msq[63:31];
                        end
                        r_b <= r_b - 5'd1;
                    end
                    if (w_rsp.done) begin
                        r_q <= (w_rsp.quo > 64'(ScoreMax)) ? 64'(ScoreMax) : w_rsp.quo;
                        r_state <= S_CLN;
                    end
                end
                S_CLN: begin
                    if (w_sum > 50'(ScoreMax)) r_score[r_c[ClsW-1:0]] <= ScoreMax;
                    else if (w_sum < 50'(ScoreMin)) r_score[r_c[ClsW-1:0]] <= ScoreMin;
                    else r_score[r_c[ClsW-1:0]] <= w_sum[47:0];
                    r_state <= S_CACC;
                    r_q <= '1;
                end
                S_CACC: begin
                    if (r_c + 1'b1 >= (ClsW+1)'(w_nc)) r_state <= S_ARG;
                    else begin
                        r_c <= r_c + 1'b1;
                        r_state <= S_CRD;
                    end
                end
                S_ARG: begin
                    r_best <= ScoreMin;
                    r_bc <= '0;
                    r_found <= 1'b0;
                    r_c <= '0;
                    if (!r_in.last_feature) begin
                        if (r_pos < 7'd64) r_pos <= r_pos + 7'd1;
                        r_state <= S_IDLE;
                    end else begin
                        r_pos <= '0;
                        r_state <= S_EMIT;
                    end
                end
                // argmax sweep, one class a cycle
                S_EMIT: begin
                    if (r_in.command == CmdClassify && r_c < (ClsW+1)'(w_nc)) begin
                        if (r_score[r_c[ClsW-1:0]] > r_best) begin
                            r_best <= r_score[r_c[ClsW-1:0]];
                            r_bc <= r_c[3:0];
                            r_found <= 1'b1;
                        end
                        r_c <= r_c + 1'b1;
                    end else begin
                        o_out.valid <= 1'b1;
                        if (r_in.command == CmdClassify) begin
                            o_out.data <= {r_bc, r_found, r_best, 32'd0};
                        end else begin
                            o_out.data <= {4'd0, 1'b0, 48'd0, r_cnt[r_in.class_id]};
                        end
                        r_state <= S_WAIT;
                    end
                end
                S_WAIT: begin
                    if (o_out.ready) begin
                        o_out.valid <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

[sim/gaussian_naive_bayes_engine_core_tb.sv]
// self-checking testbench for gaussian_naive_bayes_engine_core: directed table, then random vectors
// scored by a bit-exact predictor; depends on gnb_pkg, gnb_if and the engine rtl
`default_nettype none
module gaussian_naive_bayes_engine_core_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import gnb_pkg::*;

    localparam longint CycleLimit = 8_000_000;
    localparam int     DrainCycles = 2500;
    localparam int     PhaseBeats = 56;
    localparam longint ScoreTop = 64'sd140737488355327;
    localparam longint ScoreBottom = -64'sd140737488355328;

    logic i_clk;
    logic i_rst_n;

    gnb_in_if  in_if ();
    gnb_out_if out_if ();
    gnb_cfg_if cfg_if ();

    gaussian_naive_bayes_engine_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    // 20 ns clock
    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // predictor state, mirrors the engine's stores
    int          mean_store [Depth];
    bit [31:0]   var_store [Depth];
    bit [31:0]   count_store [MaxClasses];
    longint      score_acc [MaxClasses];
    int          elem_pos;
    bit [4:0]    classes_reg;
    bit [6:0]    features_reg;

    t_out        awaited_results[$];
    int          error_count;
    longint      cycle_count;
    int          send_idle_pct;
    int          recv_stall_pct;

    // register settings per random phase
    int          cfg_classes [8] = '{1, 16, 0, 31, 5, 2, 8, 3};
    int          cfg_features [8] = '{1, 64, 0, 127, 3, 8, 4, 2};

    // directed table row: typed expectation only where it is obvious
    typedef struct {
        t_in  beat;
        bit   typed;
        t_out want;
    } t_row;
    t_row        directed_rows[$];

    function automatic bit [63:0] magnitude(longint v);
        return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    function automatic longint clip48(longint v);
        if (v > ScoreTop) return ScoreTop;
        if (v < ScoreBottom) return ScoreBottom;
        return v;
    endfunction

    // log2 in Q16.16 by repeated squaring of the normalized mantissa
    function automatic bit [31:0] log2_fixed(bit [31:0] u);
        int        k;
        bit [31:0] frac;
        bit [63:0] m;
        k = 31;
        frac = '0;
        while (k > 0 && u[k] == 1'b0) k--;
        m = 64'(u) << (31 - k);
        for (int b = 15; b >= 0; b--) begin
            m = (m * m) >> 31;
            if (m >= 64'h1_0000_0000) begin
                m = m >> 1;
                frac[b] = 1'b1;
            end
        end
        return (32'(k) << 16) | frac;
    endfunction

    // log gaussian of one element against one stored mean/variance pair
    function automatic longint log_gauss_term(longint x, int mean, bit [31:0] vr);
        bit [31:0] v;
        bit [63:0] ad;
        bit [63:0] q;
        bit [31:0] l;
        longint    lnv;
        longint    h;
        v = (vr != 0) ? vr : 32'd1;
        ad = magnitude(x - longint'(mean));
        q = (ad * ad) / (64'(v) << 1);
        if (q > 64'(ScoreTop)) q = 64'(ScoreTop);
        l = log2_fixed(v);
        lnv = longint'((64'(l) * 64'(Ln2Q)) >> 16) - 16 * longint'(Ln2Q);
        h = (longint'(Ln2PiQ) + lnv) / 2;
        return -longint'(q) - h;
    endfunction

    // running mean / variance update for one trained element
    function automatic void welford_update(int cls, int pos, longint x);
        int        idx;
        bit [63:0] n;
        longint    mean;
        longint    delta;
        longint    nm;
        bit [63:0] p;
        bit [63:0] a;
        bit [63:0] lo;
        bit [63:0] q;
        idx = cls * MaxFeatures + pos;
        n = 64'(count_store[cls]);
        mean = longint'(mean_store[idx]);
        delta = x - mean;
        if (n == 0) return;
        nm = mean + delta / longint'(n);
        mean_store[idx] = int'(nm);
        if (n > 2) begin
            p = magnitude(delta) * magnitude(x - nm);
            a = 64'(var_store[idx]) * (n - 2);
            lo = a + (p >> 16);
            if (lo < a) begin
                q = 64'hFFFF_FFFF;
            end else begin
                q = lo / (n - 1);
                if (q > 64'hFFFF_FFFF) q = 64'hFFFF_FFFF;
            end
            var_store[idx] = q[31:0];
        end
    endfunction

    // advance the predictor by one beat; returns 1 with the result on a last beat
    function automatic bit predict_beat(t_in b, output t_out r);
        int     nc;
        int     nf;
        int     pos;
        int     cls;
        int     idx;
        longint x;
        longint best;
        r = '0;
        nc = classes_reg;
        nf = features_reg;
        if (nc < 1) nc = 1;
        if (nc > MaxClasses) nc = MaxClasses;
        if (nf < 1) nf = 1;
        if (nf > MaxFeatures) nf = MaxFeatures;
        pos = elem_pos;
        cls = b.class_id;
        x = longint'(signed'(b.feature_value));

        if (pos == 0) begin
            for (int c = 0; c < MaxClasses; c++) score_acc[c] = 0;
        end

        if (b.command == CmdTrain) begin
            if (cls < MaxClasses) begin
                if (pos == 0 && count_store[cls] != 32'hFFFF_FFFF) count_store[cls]++;
                if (pos < nf) welford_update(cls, pos, x);
            end
        end else if (pos < nf) begin
            for (int c = 0; c < nc; c++) begin
                idx = c * MaxFeatures + pos;
                if (mean_store[idx] > 0) begin
                    score_acc[c] = clip48(score_acc[c] +
                        log_gauss_term(x, mean_store[idx], var_store[idx]));
                end
            end
        end

        if (!b.last_feature) begin
            if (elem_pos < MaxFeatures) elem_pos++;
            return 1'b0;
        end
        elem_pos = 0;

        if (b.command == CmdTrain) begin
            r.class_sample_count = (cls < MaxClasses) ? count_store[cls] : 32'd0;
        end else begin
            best = ScoreBottom;
            for (int c = 0; c < nc; c++) begin
                if (score_acc[c] > best) begin
                    best = score_acc[c];
                    r.best_class = 4'(c);
                    r.class_found = 1'b1;
                end
            end
            r.best_log_likelihood = best[47:0];
        end
        return 1'b1;
    endfunction

    task automatic report_mismatch(string field, longint got, longint want);
        $display("[%0t] mismatch %s: got %0d expected %0d", $realtime, field, got, want);
        error_count++;
    endtask

    // result checker: each accepted result beat against the oldest expectation
    always @(posedge i_clk) begin
        t_out want;
        t_out got;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            got = out_if.data;
            if (awaited_results.size() == 0) begin
                $display("[%0t] result beat with nothing expected", $realtime);
                error_count++;
            end else begin
                want = awaited_results.pop_front();
                if (got.best_class !== want.best_class)
                    report_mismatch("best_class", got.best_class, want.best_class);
                if (got.class_found !== want.class_found)
                    report_mismatch("class_found", got.class_found, want.class_found);
                if (got.best_log_likelihood !== want.best_log_likelihood)
                    report_mismatch("best_log_likelihood",
                        longint'(signed'(got.best_log_likelihood)),
                        longint'(signed'(want.best_log_likelihood)));
                if (got.class_sample_count !== want.class_sample_count)
                    report_mismatch("class_sample_count",
                        got.class_sample_count, want.class_sample_count);
            end
        end
    end

    // receiver back-pressure, redrawn every falling edge
    always @(negedge i_clk) begin
        out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CycleLimit) begin
            $display("FAIL gaussian_naive_bayes_engine_core");
            $finish;
        end
    end

    // send one input beat; the predictor runs at the accepting edge
    task automatic send_beat(t_in b, bit typed, t_out typed_want);
        t_out r;
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            in_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.data <= b;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        if (predict_beat(b, r)) awaited_results = {awaited_results, (typed ? typed_want : r)};
    endtask

    // wait for every result, let any result-less beat finish, then write
    task automatic write_register(logic idx, int value);
        @(negedge i_clk);
        in_if.valid <= 1'b0;
        wait (awaited_results.size() == 0);
        repeat (DrainCycles) @(posedge i_clk);
        @(negedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.data <= '{index: idx, data: 7'(value)};
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        if (idx == RegClasses) classes_reg = 5'(value);
        else features_reg = 7'(value);
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic add_row(logic cmd, int cls, bit [31:0] x, bit last, bit typed,
                           t_out want);
        t_row row;
        row.beat = '{command: cmd, class_id: 4'(cls), feature_value: x, last_feature: last};
        row.typed = typed;
        row.want = want;
        directed_rows = {directed_rows, row};
    endtask

    // random feature value: mostly clustered positive per class so means stay scored
    function automatic bit [31:0] draw_value(int cls);
        int pick;
        pick = $urandom_range(99);
        if (pick < 70) return 32'((cls + 1) * 32'h2_0000 + $urandom_range(0, 32'hFFFF));
        if (pick < 85) return 32'h0001_0000;
        return $urandom;
    endfunction

    initial begin
        int   ncc;
        int   nfc;
        int   len;
        int   beats;
        int   cls;
        logic cmd;
        t_in  b;
        t_out none;

        // known values on every input from time zero
        i_rst_n = 1'b0;
        in_if.valid = 1'b0;
        in_if.data = '0;
        cfg_if.valid = 1'b0;
        cfg_if.data = '0;
        out_if.ready = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        error_count = 0;
        cycle_count = 0;
        none = '0;

        // predictor reset state
        for (int i = 0; i < Depth; i++) begin
            mean_store[i] = 0;
            var_store[i] = VarReset;
        end
        for (int c = 0; c < MaxClasses; c++) begin
            count_store[c] = '0;
            score_acc[c] = 0;
        end
        elem_pos = 0;
        classes_reg = 5'd16;
        features_reg = 7'd64;

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed part: 3 classes, 2 features
        write_register(RegClasses, 3);
        write_register(RegFeatures, 2);

        // nothing trained: no mean above zero, all scores 0, class 0 wins
        add_row(CmdClassify, 0, 32'h0001_0000, 1'b1, 1'b1,
                '{best_class: 4'd0, class_found: 1'b1, best_log_likelihood: 48'd0,
                  class_sample_count: 32'd0});
        // field extremes on a two-element train vector
        add_row(CmdTrain, 0, 32'h7FFF_FFFF, 1'b0, 1'b0, none);
        add_row(CmdTrain, 0, 32'h8000_0000, 1'b1, 1'b1,
                '{best_class: 4'd0, class_found: 1'b0, best_log_likelihood: 48'd0,
                  class_sample_count: 32'd1});
        // highest class id, outside the classes in use but still trained
        add_row(CmdTrain, 15, 32'h0005_0000, 1'b1, 1'b1,
                '{best_class: 4'd0, class_found: 1'b0, best_log_likelihood: 48'd0,
                  class_sample_count: 32'd1});
        // classes 1 and 2 trained alike at position 0, third sample updates variance
        add_row(CmdTrain, 1, 32'h0002_0000, 1'b1, 1'b0, none);
        add_row(CmdTrain, 1, 32'h0003_0000, 1'b1, 1'b0, none);
        add_row(CmdTrain, 1, 32'h0002_8000, 1'b1, 1'b0, none);
        add_row(CmdTrain, 2, 32'h0002_0000, 1'b1, 1'b0, none);
        add_row(CmdTrain, 2, 32'h0003_0000, 1'b1, 1'b0, none);
        // long vector: positions past features in use change nothing
        add_row(CmdTrain, 2, 32'h0002_8000, 1'b0, 1'b0, none);
        add_row(CmdTrain, 2, 32'hFFFF_0000, 1'b0, 1'b0, none);
        add_row(CmdTrain, 2, 32'h7FFF_FFFF, 1'b0, 1'b0, none);
        add_row(CmdTrain, 2, 32'h8000_0000, 1'b1, 1'b0, none);
        // tie between classes 1 and 2, lower index wins
        add_row(CmdClassify, 0, 32'h0002_8000, 1'b1, 1'b0, none);
        // long classify vector and extreme inputs
        add_row(CmdClassify, 9, 32'h0002_0000, 1'b0, 1'b0, none);
        add_row(CmdClassify, 9, 32'h0001_0000, 1'b0, 1'b0, none);
        add_row(CmdClassify, 9, 32'h7FFF_FFFF, 1'b0, 1'b0, none);
        add_row(CmdClassify, 9, 32'h8000_0000, 1'b1, 1'b0, none);
        // mixed commands: last beat picks the result kind
        add_row(CmdTrain, 1, 32'h0003_0000, 1'b0, 1'b0, none);
        add_row(CmdClassify, 1, 32'h0002_0000, 1'b1, 1'b0, none);
        add_row(CmdClassify, 0, 32'h0002_0000, 1'b0, 1'b0, none);
        add_row(CmdTrain, 1, 32'h0002_4000, 1'b1, 1'b0, none);
        add_row(CmdClassify, 0, 32'h8000_0000, 1'b1, 1'b0, none);

        foreach (directed_rows[i])
            send_beat(directed_rows[i].beat, directed_rows[i].typed, directed_rows[i].want);

        // random part: one setting per phase, idling mode rotates
        for (int ph = 0; ph < 8; ph++) begin
            write_register(RegClasses, cfg_classes[ph]);
            write_register(RegFeatures, cfg_features[ph]);
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 70; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 70; end
                default: begin send_idle_pct = 16; recv_stall_pct = 16; end
            endcase
            ncc = (cfg_classes[ph] < 1) ? 1 : (cfg_classes[ph] > 16 ? 16 : cfg_classes[ph]);
            nfc = (cfg_features[ph] < 1) ? 1 : (cfg_features[ph] > 64 ? 64 : cfg_features[ph]);
            beats = 0;
            while (beats < PhaseBeats) begin
                // mostly short vectors; now and then a full or overlong one
                if ($urandom_range(19) == 0) len = nfc + $urandom_range(0, 2);
                else len = $urandom_range(1, (nfc < 6) ? nfc : 6);
                cmd = ($urandom_range(99) < 60) ? CmdTrain : CmdClassify;
                cls = ($urandom_range(9) == 0) ? $urandom_range(0, 15)
                                                : $urandom_range(0, ncc - 1);
                for (int e = 0; e < len; e++) begin
                    b.command = ($urandom_range(99) < 8) ? ~cmd : cmd;
                    b.class_id = 4'(cls);
                    b.feature_value = draw_value(cls);
                    b.last_feature = (e == len - 1);
                    send_beat(b, 1'b0, none);
                    beats++;
                end
            end
        end

        // let everything drain
        @(negedge i_clk);
        in_if.valid <= 1'b0;
        wait (awaited_results.size() == 0);
        repeat (DrainCycles) @(posedge i_clk);

        if (error_count == 0) begin
            $display("PASS gaussian_naive_bayes_engine_core");
        end else begin
            $display("FAIL gaussian_naive_bayes_engine_core");
        end
        $finish;
    end
endmodule
`default_nettype wire

[gaussian_naive_bayes_engine_core.f]
rtl/gnb_pkg.sv
rtl/gnb_if.sv
rtl/gnb_div.sv
rtl/gaussian_naive_bayes_engine_core.sv
sim/gaussian_naive_bayes_engine_core_tb.sv
